// ===== rtl/assert_macros.svh =====
// Assertion shorthand for the link engine checkers.
// Clocked on aclk, disabled while aresetn is low; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CPL_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("link engine check failed");

// Next-cycle implication.
`define CPL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("link engine check failed");

`endif

// ===== rtl/cple_pkg.sv =====
// Shared constants, codes and control structs for the command packet link engine.
// No dependencies; imported by every module of the block.
`default_nettype none

package cple_pkg;

    localparam int REPLY_DEPTH = 32;
    localparam int ADDR_W      = $clog2(REPLY_DEPTH);
    localparam int CNT_W       = 5;

    // request types (s_tuser)
    localparam logic [1:0] REQ_CMD     = 2'd0;
    localparam logic [1:0] REQ_BYTE    = 2'd1;
    localparam logic [1:0] REQ_TIMEOUT = 2'd2;

    // result kinds (m_tuser)
    localparam logic [1:0] KIND_TX   = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    // completion codes
    localparam logic [1:0] OC_ACK     = 2'd0;
    localparam logic [1:0] OC_STATUS  = 2'd1;
    localparam logic [1:0] OC_GARBLED = 2'd2;
    localparam logic [1:0] OC_TIMEOUT = 2'd3;

    localparam logic [7:0] SYNC_RESET    = 8'h55;
    localparam logic [7:0] FRAME_LEN     = 8'd1;
    localparam logic [7:0] CMD_STAT_SHORT = 8'd1;
    localparam logic [7:0] CMD_STAT_MID  = 8'd14;
    localparam logic [7:0] CMD_STAT_LONG = 8'd20;

    localparam logic [CNT_W-1:0] LEN_ACK    = 5'd2;
    localparam logic [CNT_W-1:0] LEN_SHORT  = 5'd16;
    localparam logic [CNT_W-1:0] LEN_MID    = 5'd24;
    localparam logic [CNT_W-1:0] LEN_LONG   = 5'd27;
    localparam logic [CNT_W-1:0] LEN_TRAIL  = 5'd2;
    localparam logic [CNT_W-1:0] DATA_FIRST = 5'd4;

    localparam logic [2:0] TX_LAST = 3'd4;

    typedef struct packed {
        logic       start_cmd;
        logic       store_byte;
        logic       emit_tx;
        logic       emit_data;
        logic       emit_done;
        logic       start_stream;
        logic [1:0] done_code;
    } cple_cmd_t;

    typedef struct packed {
        logic       slot_free;
        logic       tx_last;
        logic       count_hit;
        logic       count_zero;
        logic       data_last;
        logic [1:0] reply_code;
    } cple_stat_t;

endpackage

`default_nettype wire

// ===== rtl/command_packet_link_engine.sv =====
// Top level of the command packet link engine: controller plus datapath.
// Uses cple_pkg, cple_ctrl and cple_dp.
//
//   channel   dir   tdata fields (low bit up)              tuser       tlast
//   s_        in    cmd_address, cmd_code, rx_byte         req_type    -
//   m_        out   out_byte, outcome, 6 zero bits         out_kind    last
//   cfg_      in    cfg_wr_data = sync_byte                -           -
//
// A command request is accepted, then its five-byte frame is sent. Reply bytes
// are taken one per cycle; the final byte leads to a check, and a good status
// reply streams its 11, 17 or 20 data bytes from the reply buffer at one per
// cycle while the output is not stalled, then its completion code. A timeout
// that ends a wait sends its code; bytes and timeouts while no reply is awaited
// are dropped. Output stalls freeze the sequencer; input is refused until the
// run is done. Reset is synchronous, active low, and needs no clearing pass.
`default_nettype none

module command_packet_link_engine (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // cmd_address, cmd_code, rx_byte
    input  wire logic [1:0]  s_tuser,   // req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // out_byte, outcome, zero pad
    output logic [1:0]       m_tuser,   // out_kind
    output logic             m_tlast    // last
);
    import cple_pkg::*;

    cple_cmd_t  cmd;
    cple_stat_t stat;
    logic [7:0] out_byte;
    logic [1:0] outcome;

    cple_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .req_type (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    cple_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd_address (s_tdata[7:0]),
        .cmd_code    (s_tdata[15:8]),
        .rx_byte     (s_tdata[23:16]),
        .m_tready    (m_tready),
        .cmd         (cmd),
        .stat        (stat),
        .m_tvalid    (m_tvalid),
        .out_kind    (m_tuser),
        .out_byte    (out_byte),
        .outcome     (outcome),
        .last        (m_tlast)
    );

    assign m_tdata = {6'd0, outcome, out_byte};

endmodule

`default_nettype wire

// ===== rtl/cple_ctrl.sv =====
// Controller state machine for the command packet link engine.
// Uses cple_pkg; drives cple_dp through cple_cmd_t and reads cple_stat_t.
`default_nettype none

module cple_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [1:0]          req_type,
    input  wire cple_pkg::cple_stat_t stat,
    output cple_pkg::cple_cmd_t      cmd
);
    import cple_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TX,
        ST_CHECK,
        ST_DATA,
        ST_DONE
    } state_t;

    state_t     state_reg;
    logic       wait_reg;
    logic [1:0] code_reg;
    logic       accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        cmd = '0;
        cmd.done_code = code_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (req_type)
                        REQ_CMD:  cmd.start_cmd  = 1'b1;
                        REQ_BYTE: cmd.store_byte = wait_reg;
                        default:  ;
                    endcase
                end
            end
            ST_TX:    cmd.emit_tx      = stat.slot_free;
            ST_CHECK: cmd.start_stream = (stat.reply_code == OC_STATUS);
            ST_DATA:  cmd.emit_data    = stat.slot_free;
            ST_DONE:  cmd.emit_done    = stat.slot_free;
            default:  ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            wait_reg  <= 1'b0;
            code_reg  <= OC_ACK;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        unique case (req_type)
                            REQ_CMD: begin
                                // a new command drops any reply still pending
                                wait_reg  <= 1'b1;
                                state_reg <= ST_TX;
                            end
                            REQ_BYTE: begin
                                if (wait_reg && stat.count_hit) begin
                                    wait_reg  <= 1'b0;
                                    state_reg <= ST_CHECK;
                                end
                            end
                            REQ_TIMEOUT: begin
                                if (wait_reg) begin
                                    wait_reg  <= 1'b0;
                                    code_reg  <= stat.count_zero ? OC_TIMEOUT : OC_GARBLED;
                                    state_reg <= ST_DONE;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_TX: begin
                    if (stat.slot_free && stat.tx_last) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_CHECK: begin
                    code_reg  <= stat.reply_code;
                    state_reg <= (stat.reply_code == OC_STATUS) ? ST_DATA : ST_DONE;
                end
                ST_DATA: begin
                    if (stat.slot_free && stat.data_last) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (stat.slot_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cple_dp.sv =====
// Datapath of the command packet link engine: saved command, reply buffer,
// running checksum, reply check and the output register. Uses cple_pkg.
`default_nettype none

module cple_dp (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic [7:0]          cfg_wr_data,
    input  wire logic [7:0]          cmd_address,
    input  wire logic [7:0]          cmd_code,
    input  wire logic [7:0]          rx_byte,
    input  wire logic                m_tready,
    input  wire cple_pkg::cple_cmd_t cmd,
    output cple_pkg::cple_stat_t     stat,
    output logic                     m_tvalid,
    output logic [1:0]               out_kind,
    output logic [7:0]               out_byte,
    output logic [1:0]               outcome,
    output logic                     last
);
    import cple_pkg::*;

    logic [7:0]       sync_reg;
    logic [7:0]       addr_reg;
    logic [7:0]       code_reg;
    logic [CNT_W-1:0] exp_reg;
    logic [CNT_W-1:0] eff_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [7:0]       byte0_reg;
    logic [7:0]       byte1_reg;
    logic [7:0]       byte3_reg;
    logic [7:0]       chk_reg;
    logic [7:0]       sum_reg;
    logic [2:0]       tx_idx_reg;
    logic [CNT_W-1:0] rd_idx_reg;
    logic [CNT_W-1:0] rd_idx_next;
    logic [7:0]       rdata_reg;
    logic [7:0]       mem [REPLY_DEPTH];

    logic             m_valid_reg;
    logic [1:0]       kind_reg;
    logic [7:0]       byte_reg;
    logic [1:0]       oc_reg;
    logic             last_reg;

    logic [CNT_W-1:0] len_next;
    logic [CNT_W-1:0] eff_next;
    logic [CNT_W-1:0] cnt_inc;
    logic [CNT_W-1:0] data_end;
    logic [7:0]       tx_byte;
    logic [1:0]       reply_code;
    logic             slot_free;
    logic             any_emit;

    // reply length by command
    always_comb begin
        unique case (cmd_code)
            CMD_STAT_SHORT: len_next = LEN_SHORT;
            CMD_STAT_MID:   len_next = LEN_MID;
            CMD_STAT_LONG:  len_next = LEN_LONG;
            default:        len_next = LEN_ACK;
        endcase
        eff_next = ((cmd_code == CMD_STAT_MID) || (cmd_code == CMD_STAT_LONG))
                   ? len_next - LEN_TRAIL : len_next;
    end

    assign cnt_inc  = cnt_reg + 1'b1;
    assign data_end = eff_reg - LEN_TRAIL;

    // full check once the last byte is in; sum was built as bytes arrived
    always_comb begin
        if (byte0_reg != sync_reg) begin
            reply_code = OC_GARBLED;
        end else if (exp_reg == LEN_ACK) begin
            reply_code = (byte1_reg == addr_reg) ? OC_ACK : OC_GARBLED;
        end else if ((byte1_reg != 8'd0) || (byte3_reg != addr_reg)) begin
            reply_code = OC_GARBLED;
        end else if (sum_reg != chk_reg) begin
            reply_code = OC_GARBLED;
        end else begin
            reply_code = OC_STATUS;
        end
    end

    always_comb begin
        case (tx_idx_reg)
            3'd0:    tx_byte = sync_reg;
            3'd1:    tx_byte = addr_reg;
            3'd2:    tx_byte = FRAME_LEN;
            3'd3:    tx_byte = code_reg;
            default: tx_byte = addr_reg + FRAME_LEN + code_reg;
        endcase
    end

    always_comb begin
        if (cmd.start_stream) begin
            rd_idx_next = DATA_FIRST;
        end else if (cmd.emit_data) begin
            rd_idx_next = rd_idx_reg + 1'b1;
        end else begin
            rd_idx_next = rd_idx_reg;
        end
    end

    assign slot_free = !m_valid_reg || m_tready;
    assign any_emit  = cmd.emit_tx || cmd.emit_data || cmd.emit_done;

    assign stat.slot_free  = slot_free;
    assign stat.tx_last    = (tx_idx_reg == TX_LAST);
    assign stat.count_hit  = (cnt_inc >= exp_reg);
    assign stat.count_zero = (cnt_reg == '0);
    assign stat.data_last  = (rd_idx_reg == data_end);
    assign stat.reply_code = reply_code;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_reg    <= SYNC_RESET;
            cnt_reg     <= '0;
            tx_idx_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                sync_reg <= cfg_wr_data;
            end
            if (cmd.start_cmd) begin
                cnt_reg    <= '0;
                tx_idx_reg <= '0;
            end else begin
                if (cmd.store_byte) begin
                    cnt_reg <= cnt_inc;
                end
                if (cmd.emit_tx) begin
                    tx_idx_reg <= tx_idx_reg + 1'b1;
                end
            end
            if (slot_free) begin
                m_valid_reg <= any_emit;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        rd_idx_reg <= rd_idx_next;
        if (cmd.start_cmd) begin
            addr_reg <= cmd_address;
            code_reg <= cmd_code;
            exp_reg  <= len_next;
            eff_reg  <= eff_next;
            sum_reg  <= '0;
        end
        if (cmd.store_byte) begin
            if (cnt_reg == 5'd0) byte0_reg <= rx_byte;
            if (cnt_reg == 5'd1) byte1_reg <= rx_byte;
            if (cnt_reg == 5'd3) byte3_reg <= rx_byte;
            if (cnt_reg == eff_reg - 1'b1) chk_reg <= rx_byte;
            if ((cnt_reg != '0) && (cnt_reg <= data_end)) begin
                sum_reg <= sum_reg + rx_byte;
            end
        end
        if (slot_free && any_emit) begin
            if (cmd.emit_tx) begin
                kind_reg <= KIND_TX;
                byte_reg <= tx_byte;
                oc_reg   <= OC_ACK;
                last_reg <= (tx_idx_reg == TX_LAST);
            end else if (cmd.emit_data) begin
                kind_reg <= KIND_DATA;
                byte_reg <= rdata_reg;
                oc_reg   <= OC_ACK;
                last_reg <= 1'b0;
            end else begin
                kind_reg <= KIND_DONE;
                byte_reg <= 8'd0;
                oc_reg   <= cmd.done_code;
                last_reg <= 1'b1;
            end
        end
    end

    // reply buffer; read address runs one step ahead of rd_idx_reg
    always_ff @(posedge aclk) begin
        if (cmd.store_byte && (32'(cnt_reg) < REPLY_DEPTH)) begin
            mem[ADDR_W'(cnt_reg)] <= rx_byte;
        end
        rdata_reg <= mem[ADDR_W'(rd_idx_next)];
    end

    assign m_tvalid = m_valid_reg;
    assign out_kind = kind_reg;
    assign out_byte = byte_reg;
    assign outcome  = oc_reg;
    assign last     = last_reg;

endmodule

`default_nettype wire

// ===== rtl/cple_checker.sv =====
// Port-level checks for the command packet link engine, bound to the top level.
// Uses cple_pkg and the macros in assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module cple_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [1:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);
    import cple_pkg::*;

    `CPL_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    // a command request always starts a frame, so input closes right after
    `CPL_ASSERT_NEXT(a_cmd_busy, s_tvalid && s_tready && (s_tuser == REQ_CMD), !s_tready)

    `CPL_ASSERT_NOW(a_done_shape, m_tvalid && (m_tuser == KIND_DONE),
        m_tlast && (m_tdata[7:0] == 8'd0))

    `CPL_ASSERT_NOW(a_byte_shape, m_tvalid && (m_tuser != KIND_DONE),
        (m_tdata[9:8] == OC_ACK) && !((m_tuser == KIND_DATA) && m_tlast))

    `CPL_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[15:10] == 6'd0)

endmodule

bind command_packet_link_engine cple_checker u_cple_checker (.*);

`default_nettype wire
